// File: hdl/psbb_pkg.sv
// Shared constants and controller/datapath interface types for the point sprite box.
`timescale 1ns / 1ps
package psbb_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int DIVD_W     = COORD_BITS - 1 + FRAC_BITS;
  localparam int SQ_W       = 2 * COORD_BITS - 1;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int SQRT_STEPS = COORD_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] CW_RESET = COORD_BITS'(1) << FRAC_BITS;

  localparam logic REG_CONSTANT_WIDTH = 1'b0;
  localparam logic REG_PATCH_MODE     = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_w;
    logic mul_rr;
    logic mul_hh;
    logic radius;
    logic div_init;
    logic div_step;
    logic div_done;
    logic sq_sum;
    logic sqrt_step;
    logic sqrt_done;
    logic widen;
  } psbb_cmd_t;

  typedef struct packed {
    logic patch;
    logic ar_zero;
    logic last;
    logic out_busy;
  } psbb_sts_t;

endpackage

// File: hdl/point_sprite_bounding_box_core.sv
// Top level of the point sprite bounding box: controller, datapath and port wiring.
// A closing request shows its box after the load, width multiply, radius and widen steps outside
// patch mode; in patch mode the 47-step radix-2 divider (skipped with a zero aspect ratio) and
// the 32-step square root run between radius and widen. One request is in work at a time, so a
// new one is taken only once the last has left its widen step. A closing request waits in its
// last step while an earlier box is still not taken. Synchronous active-low reset empties the
// box, drops the result and restores the registers.
`timescale 1ns / 1ps
module point_sprite_bounding_box_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic        [psbb_pkg::COORD_BITS-1:0] cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_z,
  input  logic        [psbb_pkg::COORD_BITS-1:0] in_point_width,
  input  logic        [psbb_pkg::COORD_BITS-1:0] in_aspect_ratio,
  input  logic                                   in_last_point,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_min_x,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_min_y,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_min_z,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_max_x,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_max_y,
  output logic signed [psbb_pkg::COORD_BITS-1:0] out_box_max_z
);

  psbb_pkg::psbb_cmd_t             cmd;
  psbb_pkg::psbb_sts_t             sts;
  logic [psbb_pkg::COORD_BITS-1:0] box_lo [3];
  logic [psbb_pkg::COORD_BITS-1:0] box_hi [3];

  psbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psbb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_point_width  (in_point_width),
    .in_aspect_ratio (in_aspect_ratio),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lo          (box_lo),
    .out_hi          (box_hi)
  );

  assign out_box_min_x = box_lo[0];
  assign out_box_min_y = box_lo[1];
  assign out_box_min_z = box_lo[2];
  assign out_box_max_x = box_hi[0];
  assign out_box_max_y = box_hi[1];
  assign out_box_max_z = box_hi[2];

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("controller took a request without leaving idle");

  a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.widen && sts.last))
    else $error("result raised without a closing request");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.widen && sts.last) |-> !(out_valid && out_stall))
    else $error("pending box overwritten");

endmodule

// File: hdl/psbb_ctrl.sv
// Sequencing state machine for the point sprite box: steps the shared datapath per request.
`timescale 1ns / 1ps
module psbb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psbb_pkg::psbb_sts_t sts,
  output psbb_pkg::psbb_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULW, ST_RAD, ST_DIVI, ST_DIV, ST_DIVF,
    ST_SQR, ST_SQH, ST_SUM, ST_SQRT, ST_SQF, ST_WIDEN
  } state_t;

  state_t                     state_r, state_nxt;
  logic [psbb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MULW;
        end
      end
      ST_MULW: begin
        cmd.mul_w = 1'b1;
        state_nxt = ST_RAD;
      end
      ST_RAD: begin
        cmd.radius = 1'b1;
        state_nxt  = sts.patch ? ST_DIVI : ST_WIDEN;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = psbb_pkg::CNT_W'(psbb_pkg::DIV_STEPS);
        state_nxt    = sts.ar_zero ? ST_SQR : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == psbb_pkg::CNT_W'(1)) state_nxt = ST_DIVF;
      end
      ST_DIVF: begin
        cmd.div_done = 1'b1;
        state_nxt    = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_rr = 1'b1;
        state_nxt  = ST_SQH;
      end
      ST_SQH: begin
        cmd.mul_hh = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sq_sum = 1'b1;
        cnt_nxt    = psbb_pkg::CNT_W'(psbb_pkg::SQRT_STEPS);
        state_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == psbb_pkg::CNT_W'(1)) state_nxt = ST_SQF;
      end
      ST_SQF: begin
        cmd.sqrt_done = 1'b1;
        state_nxt     = ST_WIDEN;
      end
      ST_WIDEN: begin
        // A closing request waits until the previous box has been taken.
        if (!(sts.last && sts.out_busy)) begin
          cmd.widen = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hdl/psbb_dp.sv
// Datapath for the point sprite box: multiplier, divider, square root and box registers.
`timescale 1ns / 1ps
module psbb_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  psbb_pkg::psbb_cmd_t                    cmd,
  output psbb_pkg::psbb_sts_t                    sts,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic        [psbb_pkg::COORD_BITS-1:0] cfg_wdata,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [psbb_pkg::COORD_BITS-1:0] in_point_z,
  input  logic        [psbb_pkg::COORD_BITS-1:0] in_point_width,
  input  logic        [psbb_pkg::COORD_BITS-1:0] in_aspect_ratio,
  input  logic                                   in_last_point,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [psbb_pkg::COORD_BITS-1:0] out_lo [3],
  output logic        [psbb_pkg::COORD_BITS-1:0] out_hi [3]
);

  localparam int CW = psbb_pkg::COORD_BITS;
  localparam int FW = psbb_pkg::FRAC_BITS;
  localparam int PW = psbb_pkg::PROD_W;
  localparam int DW = psbb_pkg::DIVD_W;
  localparam int SW = psbb_pkg::SQ_W;

  logic [CW-1:0] cw_r;
  logic          patch_r;
  logic [CW-1:0] pos_r [3];
  logic [CW-1:0] pw_r, ar_r;
  logic          last_r;
  logic [PW-1:0] prod_r, acc_r;
  logic [CW-1:0] mul_a, mul_b;
  logic [CW-1:0] rad_r, hh_r;
  logic [CW:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;
  logic [SW-1:0] sq_n_r, sq_res_r, sq_bit_r, sq_trial;
  logic [CW-1:0] lo_r [3];
  logic [CW-1:0] hi_r [3];
  logic [CW-1:0] lo_new [3];
  logic [CW-1:0] hi_new [3];
  logic          out_valid_r;

  function automatic logic [CW-1:0] sat_step(input logic [CW-1:0] p,
                                             input logic [CW-1:0] r,
                                             input logic          sub);
    logic [CW:0] s;
    begin
      s = sub ? ({p[CW-1], p} - {1'b0, r}) : ({p[CW-1], p} + {1'b0, r});
      if (s[CW] != s[CW-1]) sat_step = s[CW] ? psbb_pkg::CMIN : psbb_pkg::CMAX;
      else sat_step = s[CW-1:0];
    end
  endfunction

  assign sts.patch    = patch_r;
  assign sts.ar_zero  = (ar_r == '0);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;

  always_comb begin
    priority if (cmd.mul_rr) begin
      mul_a = rad_r;
      mul_b = rad_r;
    end else if (cmd.mul_hh) begin
      mul_a = hh_r;
      mul_b = hh_r;
    end else begin
      mul_a = cw_r;
      mul_b = pw_r;
    end
  end

  assign rem_sh   = {rem_r[CW-1:0], quo_r[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, ar_r};
  assign sq_trial = sq_res_r + sq_bit_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [CW-1:0] a, b;
      a = sat_step(pos_r[i], rad_r, 1'b1);
      b = sat_step(pos_r[i], rad_r, 1'b0);
      lo_new[i] = ($signed(a) < $signed(lo_r[i])) ? a : lo_r[i];
      hi_new[i] = ($signed(b) > $signed(hi_r[i])) ? b : hi_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r        <= psbb_pkg::CW_RESET;
      patch_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= psbb_pkg::CMAX;
        hi_r[i] <= psbb_pkg::CMIN;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          psbb_pkg::REG_CONSTANT_WIDTH: cw_r    <= cfg_wdata;
          psbb_pkg::REG_PATCH_MODE:     patch_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.widen) begin
        if (last_r) begin
          out_valid_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            lo_r[i] <= psbb_pkg::CMAX;
            hi_r[i] <= psbb_pkg::CMIN;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            lo_r[i] <= lo_new[i];
            hi_r[i] <= hi_new[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r[0] <= in_point_x;
      pos_r[1] <= in_point_y;
      pos_r[2] <= in_point_z;
      pw_r     <= in_point_width;
      ar_r     <= in_aspect_ratio;
      last_r   <= in_last_point;
    end
    if (cmd.mul_w || cmd.mul_rr || cmd.mul_hh) prod_r <= mul_a * mul_b;
    if (cmd.mul_hh) acc_r <= prod_r;
    if (cmd.radius) begin
      if (prod_r[PW-1:CW+FW] != '0) rad_r <= psbb_pkg::CMAX;
      else rad_r <= {1'b0, prod_r[CW+FW-1:FW+1]};
    end
    if (cmd.div_init) begin
      hh_r  <= rad_r;
      rem_r <= '0;
      quo_r <= {rad_r[CW-2:0], {FW{1'b0}}};
    end
    if (cmd.div_step) begin
      if (!rem_sub[CW]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.div_done) begin
      if (quo_r[DW-1:CW-1] != '0) hh_r <= psbb_pkg::CMAX;
      else hh_r <= {1'b0, quo_r[CW-2:0]};
    end
    if (cmd.sq_sum) begin
      sq_n_r   <= acc_r[SW-1:0] + prod_r[SW-1:0];
      sq_res_r <= '0;
      sq_bit_r <= SW'(1) << (SW - 1);
    end
    if (cmd.sqrt_step) begin
      if (sq_n_r >= sq_trial) begin
        sq_n_r   <= sq_n_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.sqrt_done) begin
      if (sq_res_r[SW-1:CW-1] != '0) rad_r <= psbb_pkg::CMAX;
      else rad_r <= {1'b0, sq_res_r[CW-2:0]};
    end
    if (cmd.widen && last_r) begin
      for (int i = 0; i < 3; i++) begin
        out_lo[i] <= lo_new[i];
        out_hi[i] <= hi_new[i];
      end
    end
  end

endmodule

// File: verif/point_sprite_bounding_box_core_tb.sv
// Self-checking testbench for the point sprite bounding box core.
`timescale 1ns / 1ps
module point_sprite_bounding_box_core_tb;

  typedef struct {
    logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = psbb_pkg::REG_CONSTANT_WIDTH;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic [31:0] in_point_width = '0, in_aspect_ratio = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_box_min_x, out_box_min_y, out_box_min_z;
  logic signed [31:0] out_box_max_x, out_box_max_y, out_box_max_z;

  point_sprite_bounding_box_core dut (.*);

  always #5 clk = ~clk;

  logic [31:0] width_scale;
  logic patch_on;
  longint run_lo[3], run_hi[3];
  box_t boxes_due[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int mismatches = 0, boxes_seen = 0, points_sent = 0, idle_cycles = 0;
  bit timed_out = 1'b0;
  localparam int WATCHDOG = 20000;

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned clamp_radius(longint unsigned v);
    return (v > 64'd2147483647) ? 64'd2147483647 : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic empty_box();
    for (int a = 0; a < 3; a++) begin
      run_lo[a] = 64'sd2147483647;
      run_hi[a] = -64'sd2147483648;
    end
  endtask

  task automatic grow_box(logic signed [31:0] px, py, pz, logic [31:0] pw, ar, logic lastp);
    longint unsigned r, hh;
    longint pos[3];
    box_t b;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    r = clamp_radius((longint'(width_scale) * longint'(pw)) >> (psbb_pkg::FRAC_BITS + 1));
    if (patch_on) begin
      hh = r;
      if (ar != 0) hh = clamp_radius((r << psbb_pkg::FRAC_BITS) / ar);
      r = clamp_radius(int_root(r * r + hh * hh));
    end
    for (int a = 0; a < 3; a++) begin
      if (clamp_coord(pos[a] - longint'(r)) < run_lo[a])
        run_lo[a] = clamp_coord(pos[a] - longint'(r));
      if (clamp_coord(pos[a] + longint'(r)) > run_hi[a])
        run_hi[a] = clamp_coord(pos[a] + longint'(r));
    end
    if (lastp) begin
      b.min_x = 32'(run_lo[0]); b.min_y = 32'(run_lo[1]); b.min_z = 32'(run_lo[2]);
      b.max_x = 32'(run_hi[0]); b.max_y = 32'(run_hi[1]); b.max_z = 32'(run_hi[2]);
      boxes_due.push_back(b);
      empty_box();
    end
  endtask

  task automatic send_point(logic signed [31:0] px, py, pz, logic [31:0] pw, ar, logic lastp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_point_width <= pw; in_aspect_ratio <= ar; in_last_point <= lastp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grow_box(px, py, pz, pw, ar, lastp);
    points_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == psbb_pkg::REG_CONSTANT_WIDTH) width_scale = val;
    else patch_on = val[0];
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h0003_0000);
      3: return -$urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(4))
      0: return 32'h0001_0000;
      1: return '0;
      2: return $urandom;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic random_sets(int n);
    int i;
    i = 0;
    while (i < n) begin
      int len;
      len = $urandom_range(6, 1);
      for (int k = 0; k < len && i < n; k++, i++) begin
        send_point(rand_word(), rand_word(), rand_word(), rand_size(),
                   ($urandom_range(3) == 0) ? 32'd0 : rand_size(),
                   (k == len - 1) || ($urandom_range(15) == 0));
      end
    end
  endtask

  task automatic test_directed();
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'hFFFF_FFFF, 0, 1'b1);
    send_point(0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
    send_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 32'h0001_0000, 0, 1'b0);
    send_point(-32'sh0005_0000, 32'sh0003_0000, 32'sh7FFF_0000, 32'h0002_0000, 0, 1'b1);
    write_reg(psbb_pkg::REG_PATCH_MODE, 32'd1);
    send_point(0, 0, 0, 32'h0001_0000, 0, 1'b1);
    send_point(0, 0, 0, 32'h0001_0000, 32'h0000_0001, 1'b1);
    send_point(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 32'h0003_0000, 32'h0002_0000, 1'b1);
    write_reg(psbb_pkg::REG_CONSTANT_WIDTH, 32'hFFFF_FFFF);
    send_point(-1, 1, 0, 32'hFFFF_FFFF, 32'h0000_8000, 1'b1);
    write_reg(psbb_pkg::REG_CONSTANT_WIDTH, 32'd0);
    send_point(32'sh1234_5678, -32'sh1234_5678, 5, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
    write_reg(psbb_pkg::REG_PATCH_MODE, 32'd0);
    send_point(32'sh1234_5678, 0, 0, 32'hFFFF_FFFF, 0, 1'b1);
    write_reg(psbb_pkg::REG_CONSTANT_WIDTH, 32'h0001_0000);
  endtask

  task automatic test_random_phases();
    int pcts[4][2] = '{'{0, 0}, '{47, 0}, '{0, 47}, '{21, 21}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      write_reg(psbb_pkg::REG_PATCH_MODE, p[0]);
      write_reg(psbb_pkg::REG_CONSTANT_WIDTH, (p == 3) ? $urandom : 32'h0000_8000 << p);
      random_sets(170);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_reg(psbb_pkg::REG_PATCH_MODE, 32'd0);
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_sets(60);
    join
    wait_drained();
    random_sets(30);
  endtask

  always @(posedge clk) begin
    out_stall <= hold_recv || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      box_t e;
      boxes_seen++;
      if (boxes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected box result at %0t", $realtime);
      end else begin
        e = boxes_due.pop_front();
        if (e.min_x !== out_box_min_x || e.min_y !== out_box_min_y ||
            e.min_z !== out_box_min_z || e.max_x !== out_box_max_x ||
            e.max_y !== out_box_max_y || e.max_z !== out_box_max_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Box mismatch: expected min %h %h %h max %h %h %h, got min %h %h %h max %h %h %h",
                     e.min_x, e.min_y, e.min_z, e.max_x, e.max_y, e.max_z,
                     out_box_min_x, out_box_min_y, out_box_min_z,
                     out_box_max_x, out_box_max_y, out_box_max_z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Watchdog expired after %0d idle cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    width_scale = psbb_pkg::CW_RESET;
    patch_on = 1'b0;
    empty_box();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("Sent %0d points and checked %0d boxes over both modes and several widths,",
             points_sent, boxes_seen);
    $display("with idle, stall and long hold-off phases on both channels.");
    if (mismatches == 0 && boxes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d boxes missing", mismatches, boxes_due.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
